FILE: hdl/stick_channel_payload_framer_core_defines.svh
// ----------------------------------------------------------------------------
// Stick channel payload framer - assertion macros
// Shared concurrent assertion helpers for the framer RTL.
// ----------------------------------------------------------------------------
`ifndef STICK_CHANNEL_PAYLOAD_FRAMER_CORE_DEFINES_SVH
`define STICK_CHANNEL_PAYLOAD_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SCPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SCPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/scpf_pkg.sv
// ----------------------------------------------------------------------------
// scpf_pkg
// Types and constants shared by the stick channel payload framer.
// ----------------------------------------------------------------------------
`default_nettype none

package scpf_pkg;

    localparam int CHANNEL_COUNT = 4;
    localparam int CH_W          = 11;
    localparam int SPAN_W        = 10;
    localparam int VAL_W         = 16;
    localparam int PROD_W        = VAL_W + SPAN_W + 1;
    localparam int RAW_W         = CH_W + 2;
    localparam int FLAGS_W       = 32;
    localparam int AXIS_W        = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int WORD_W        = 64;
    localparam int ROUND_SHIFT   = 14;

    // Channel field offsets inside the packed word, and the fixed marker bit
    localparam int CH_SHIFT [CHANNEL_COUNT] = '{8, 19, 30, 41};
    localparam int MARK_BIT = 62;

    // Frame layout
    localparam int FRAME_LEN = 18;
    localparam int CNT_W     = 5;
    localparam logic [CNT_W-1:0] BYTE_LEN_POS   = CNT_W'(1);
    localparam logic [CNT_W-1:0] BYTE_FLAGS_POS = CNT_W'(10);
    localparam logic [CNT_W-1:0] BYTE_TAIL_POS  = CNT_W'(14);
    localparam logic [CNT_W-1:0] BYTE_LAST_POS  = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] BYTE_WORD_POS  = CNT_W'(2);
    localparam logic [7:0] HDR_ID  = 8'h01;
    localparam logic [7:0] HDR_LEN = 8'd13;
    localparam logic [7:0] TAIL_BYTES [4] = '{8'h06, 8'h55, 8'h01, 8'h04};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLAGS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT3  = 3'd6;

    // Axis codes; anything else selects zero
    localparam logic [AXIS_W-1:0] AXIS_ROLL     = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_PITCH    = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_YAW      = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_THROTTLE = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_ZERO     = 3'd4;

    // Reset values
    localparam logic [CH_W-1:0]    CENTER_RST = 11'd1024;
    localparam logic [SPAN_W-1:0]  SPAN_RST   = 10'd660;
    localparam logic [FLAGS_W-1:0] FLAGS_RST  = 32'd0;

    typedef logic signed [VAL_W-1:0]  t_q14;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [RAW_W-1:0]  t_raw;

    typedef struct packed {
        logic [CH_W-1:0]   center;
        logic [SPAN_W-1:0] span;
        logic [CHANNEL_COUNT-1:0][AXIS_W-1:0] slot_axis;
    } t_cfg;

    // Packed word handed from the datapath to the serializer
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
    } t_word_out;

endpackage

`default_nettype wire

FILE: hdl/scpf_datapath.sv
// ----------------------------------------------------------------------------
// scpf_datapath
// Four-stage channel pipeline: axis select, scale, round, clamp and pack.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stick_channel_payload_framer_core_defines.svh"

module scpf_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire scpf_pkg::t_cfg       i_cfg,
    input  wire logic                 i_in_valid,
    input  wire scpf_pkg::t_q14 [3:0] i_axes,
    output logic                      o_in_free,
    output scpf_pkg::t_word_out       o_out,
    input  wire logic                 i_out_ready
);

    localparam int N = scpf_pkg::CHANNEL_COUNT;

    logic r_v1, r_v2, r_v3, r_v4;
    scpf_pkg::t_q14  r_sel  [N];
    scpf_pkg::t_prod r_prod [N];
    scpf_pkg::t_raw  r_raw  [N];
    logic [scpf_pkg::WORD_W-1:0] r_word;

    scpf_pkg::t_q14  n_sel  [N];
    scpf_pkg::t_prod n_prod [N];
    scpf_pkg::t_raw  n_raw  [N];
    logic [scpf_pkg::WORD_W-1:0] n_word;

    logic free4, free3, free2, free1, load1;

    // Stage advance: a stage moves when the one after it is empty or moving
    assign free4 = !r_v4 || i_out_ready;
    assign free3 = !r_v3 || free4;
    assign free2 = !r_v2 || free3;
    assign free1 = !r_v1 || free2;
    assign load1 = i_in_valid && free1;
    assign o_in_free = free1;

    // Select the axis for each slot
    always_comb begin
        for (int i = 0; i < N; i++) begin
            unique case (i_cfg.slot_axis[i])
                scpf_pkg::AXIS_ROLL:     n_sel[i] = i_axes[0];
                scpf_pkg::AXIS_PITCH:    n_sel[i] = i_axes[1];
                scpf_pkg::AXIS_YAW:      n_sel[i] = i_axes[2];
                scpf_pkg::AXIS_THROTTLE: n_sel[i] = i_axes[3];
                default:                 n_sel[i] = '0;
            endcase
        end
    end

    // Scale by span
    always_comb begin
        for (int i = 0; i < N; i++) begin
            n_prod[i] = r_sel[i] * $signed({1'b0, i_cfg.span});
        end
    end

    // Round half away from zero and add center
    always_comb begin
        logic                       neg;
        logic [scpf_pkg::PROD_W-1:0] mag;
        logic [scpf_pkg::PROD_W-1:0] sum;
        logic [scpf_pkg::RAW_W-2:0]  q;
        for (int i = 0; i < N; i++) begin
            neg = r_prod[i][scpf_pkg::PROD_W-1];
            mag = neg ? scpf_pkg::PROD_W'(-r_prod[i]) : scpf_pkg::PROD_W'(r_prod[i]);
            sum = mag + scpf_pkg::PROD_W'(1 << (scpf_pkg::ROUND_SHIFT - 1));
            q   = sum[scpf_pkg::ROUND_SHIFT +: (scpf_pkg::RAW_W - 1)];
            n_raw[i] = $signed({2'b00, i_cfg.center})
                     + (neg ? -$signed({1'b0, q}) : $signed({1'b0, q}));
        end
    end

    // Clamp to center +/- span, mask and pack
    always_comb begin
        scpf_pkg::t_raw hi;
        scpf_pkg::t_raw lo;
        scpf_pkg::t_raw v;
        hi = $signed({2'b00, i_cfg.center}) + $signed({3'b000, i_cfg.span});
        lo = $signed({2'b00, i_cfg.center}) - $signed({3'b000, i_cfg.span});
        n_word = '0;
        n_word[scpf_pkg::MARK_BIT] = 1'b1;
        for (int i = 0; i < N; i++) begin
            v = r_raw[i];
            if (v > hi) begin
                v = hi;
            end
            if (v < lo) begin
                v = lo;
            end
            n_word[scpf_pkg::CH_SHIFT[i] +: scpf_pkg::CH_W] = v[scpf_pkg::CH_W-1:0];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (free4) r_v4 <= r_v3;
            if (free3) r_v3 <= r_v2;
            if (free2) r_v2 <= r_v1;
            if (free1) r_v1 <= i_in_valid;
        end
    end

    // Payload registers, held while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (load1) r_sel <= n_sel;
        if (free2 && r_v1) r_prod <= n_prod;
        if (free3 && r_v2) r_raw <= n_raw;
        if (free4 && r_v3) r_word <= n_word;
    end

    assign o_out.valid = r_v4;
    assign o_out.word  = r_word;

    `SCPF_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, r_v4 && !i_out_ready, r_v4 && $stable(r_word), "stalled word changed")
    `SCPF_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, load1, r_v1, "accepted item not in first stage")

endmodule

`default_nettype wire

FILE: hdl/scpf_serializer.sv
// ----------------------------------------------------------------------------
// scpf_serializer
// Emits the 18-byte payload for each packed word, one byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stick_channel_payload_framer_core_defines.svh"

module scpf_serializer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire scpf_pkg::t_word_out           i_word,
    output logic                               o_ready,
    input  wire logic [scpf_pkg::FLAGS_W-1:0]  i_flags,
    output logic [7:0]                         o_byte,
    output logic                               o_last,
    output logic                               o_valid
);

    logic                         r_active;
    logic [scpf_pkg::CNT_W-1:0]   r_cnt;
    logic [scpf_pkg::WORD_W-1:0]  r_word;
    logic                         at_last, load;
    logic [scpf_pkg::CNT_W-1:0]   off_word, off_flags, off_tail;

    assign at_last = r_active && (r_cnt == scpf_pkg::BYTE_LAST_POS);
    assign o_ready = !r_active || at_last;
    assign load    = i_word.valid && o_ready;

    // Advance the byte counter, reload on the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (load) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (at_last) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (r_active) begin
            r_cnt <= r_cnt + scpf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_word <= i_word.word;
    end

    // Pick the byte for the current position
    assign off_word  = r_cnt - scpf_pkg::BYTE_WORD_POS;
    assign off_flags = r_cnt - scpf_pkg::BYTE_FLAGS_POS;
    assign off_tail  = r_cnt - scpf_pkg::BYTE_TAIL_POS;

    always_comb begin
        priority if (r_cnt == '0) begin
            o_byte = scpf_pkg::HDR_ID;
        end else if (r_cnt == scpf_pkg::BYTE_LEN_POS) begin
            o_byte = scpf_pkg::HDR_LEN;
        end else if (r_cnt < scpf_pkg::BYTE_FLAGS_POS) begin
            o_byte = r_word[{off_word[2:0], 3'b000} +: 8];
        end else if (r_cnt < scpf_pkg::BYTE_TAIL_POS) begin
            o_byte = i_flags[{off_flags[1:0], 3'b000} +: 8];
        end else begin
            o_byte = scpf_pkg::TAIL_BYTES[off_tail[1:0]];
        end
    end

    assign o_valid = r_active;
    assign o_last  = at_last;

    `SCPF_ASSERT_NEXT(a_load_starts, i_clk, i_rst_n, load, r_active && (r_cnt == '0), "word load did not restart frame")
    `SCPF_ASSERT_NEXT(a_count_steps, i_clk, i_rst_n, r_active && !at_last, r_active && (r_cnt == $past(r_cnt) + 5'd1), "byte counter skipped")

endmodule

`default_nettype wire

FILE: hdl/stick_channel_payload_framer_core.sv
// ----------------------------------------------------------------------------
// stick_channel_payload_framer_core
// Maps four Q2.14 stick values onto four 11-bit channels, packs them and
// frames them with the flags word into an 18-byte payload.
// ----------------------------------------------------------------------------
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+------------------
//  sticks   | i_roll/pitch/yaw/throttle_value            | i_start, o_busy
//  payload  | o_frame_byte, o_frame_last                 | o_frame_valid
//  config   | i_cfg_index, i_cfg_wdata                   | i_cfg_we
//
// A word is taken when i_start is high and o_busy is low. The channel
// pipeline has four stages (select, scale, round, pack), and the serializer
// registers each packed word before sending its first payload byte; the 18
// bytes follow on consecutive cycles.
// The sustained word rate is set by the byte-wide payload port; up to four
// further words queue in the pipeline while a frame is sent.
// Reset is synchronous, clears control state and restores the default config.
// The payload receiver cannot stall; o_busy rises only when the pipeline fills.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_channel_payload_framer_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic signed [15:0]                i_roll_value,
    input  wire logic signed [15:0]                i_pitch_value,
    input  wire logic signed [15:0]                i_yaw_value,
    input  wire logic signed [15:0]                i_throttle_value,
    output logic                                   o_frame_valid,
    output logic [7:0]                             o_frame_byte,
    output logic                                   o_frame_last,
    input  wire logic                              i_cfg_we,
    input  wire logic [scpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [scpf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic [scpf_pkg::CH_W-1:0]    r_center;
    logic [scpf_pkg::SPAN_W-1:0]  r_span;
    logic [scpf_pkg::FLAGS_W-1:0] r_flags;
    logic [scpf_pkg::CHANNEL_COUNT-1:0][scpf_pkg::AXIS_W-1:0] r_slot;

    scpf_pkg::t_cfg       cfg;
    scpf_pkg::t_q14 [3:0] axes;
    scpf_pkg::t_word_out  dp_out;
    logic                 in_free, ser_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= scpf_pkg::CENTER_RST;
            r_span   <= scpf_pkg::SPAN_RST;
            r_flags  <= scpf_pkg::FLAGS_RST;
            r_slot[0] <= scpf_pkg::AXIS_ROLL;
            r_slot[1] <= scpf_pkg::AXIS_PITCH;
            r_slot[2] <= scpf_pkg::AXIS_YAW;
            r_slot[3] <= scpf_pkg::AXIS_THROTTLE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                scpf_pkg::REG_CENTER: r_center  <= i_cfg_wdata[scpf_pkg::CH_W-1:0];
                scpf_pkg::REG_SPAN:   r_span    <= i_cfg_wdata[scpf_pkg::SPAN_W-1:0];
                scpf_pkg::REG_FLAGS:  r_flags   <= i_cfg_wdata[scpf_pkg::FLAGS_W-1:0];
                scpf_pkg::REG_SLOT0:  r_slot[0] <= i_cfg_wdata[scpf_pkg::AXIS_W-1:0];
                scpf_pkg::REG_SLOT1:  r_slot[1] <= i_cfg_wdata[scpf_pkg::AXIS_W-1:0];
                scpf_pkg::REG_SLOT2:  r_slot[2] <= i_cfg_wdata[scpf_pkg::AXIS_W-1:0];
                scpf_pkg::REG_SLOT3:  r_slot[3] <= i_cfg_wdata[scpf_pkg::AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.center    = r_center;
    assign cfg.span      = r_span;
    assign cfg.slot_axis = r_slot;

    assign axes[0] = i_roll_value;
    assign axes[1] = i_pitch_value;
    assign axes[2] = i_yaw_value;
    assign axes[3] = i_throttle_value;

    assign o_busy = !in_free;

    scpf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_start),
        .i_axes      (axes),
        .o_in_free   (in_free),
        .o_out       (dp_out),
        .i_out_ready (ser_ready)
    );

    scpf_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (dp_out),
        .o_ready (ser_ready),
        .i_flags (r_flags),
        .o_byte  (o_frame_byte),
        .o_last  (o_frame_last),
        .o_valid (o_frame_valid)
    );

endmodule

`default_nettype wire

FILE: test/stick_channel_payload_framer_core_tb.sv
// ----------------------------------------------------------------------------
// stick_channel_payload_framer_core_tb
// Drives stick words into the framer and checks every payload byte against a
// local prediction of the channel mapping, packing and framing. Configuration
// changes only while the framer is drained. Directed cases cover rounding,
// clamping, wrap and axis selection. Random traffic with sender gaps follows.
// ----------------------------------------------------------------------------

module stick_channel_payload_framer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 500;
    localparam int PHASE_COUNT   = 10;
    localparam int HALF_LSB      = 1 << (scpf_pkg::ROUND_SHIFT - 1);

    // Index past the register list, and axis codes that read as zero
    localparam logic [scpf_pkg::CFG_IDX_W-1:0] REG_NONE   = 3'd7;
    localparam logic [scpf_pkg::AXIS_W-1:0]    AXIS_RSVD5 = 3'd5;
    localparam logic [scpf_pkg::AXIS_W-1:0]    AXIS_RSVD6 = 3'd6;
    localparam logic [scpf_pkg::AXIS_W-1:0]    AXIS_RSVD7 = 3'd7;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_start;
    logic                            o_busy;
    scpf_pkg::t_q14                  i_roll_value;
    scpf_pkg::t_q14                  i_pitch_value;
    scpf_pkg::t_q14                  i_yaw_value;
    scpf_pkg::t_q14                  i_throttle_value;
    logic                            o_frame_valid;
    logic [7:0]                      o_frame_byte;
    logic                            o_frame_last;
    logic                            i_cfg_we;
    logic [scpf_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [scpf_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    // Local copy of the framer configuration
    logic [scpf_pkg::CH_W-1:0]    cfg_center;
    logic [scpf_pkg::SPAN_W-1:0]  cfg_span;
    logic [scpf_pkg::FLAGS_W-1:0] cfg_flags;
    logic [scpf_pkg::AXIS_W-1:0]  cfg_axis [scpf_pkg::CHANNEL_COUNT];

    t_frame_byte expected_bytes [$];
    int          error_count  = 0;
    int          stall_cycles = 0;
    int          gap_pct      = 0;

    stick_channel_payload_framer_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_roll_value     (i_roll_value),
        .i_pitch_value    (i_pitch_value),
        .i_yaw_value      (i_yaw_value),
        .i_throttle_value (i_throttle_value),
        .o_frame_valid    (o_frame_valid),
        .o_frame_byte     (o_frame_byte),
        .o_frame_last     (o_frame_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Scale one stick by the span, round half away from zero, clamp, wrap to 11 bits
    function automatic logic [scpf_pkg::CH_W-1:0] channel_code(input scpf_pkg::t_q14 stick);
        int prod;
        int step;
        int raw;
        prod = int'(stick) * int'(cfg_span);
        if (prod >= 0) begin
            step = (prod + HALF_LSB) >>> scpf_pkg::ROUND_SHIFT;
        end else begin
            step = -((-prod + HALF_LSB) >>> scpf_pkg::ROUND_SHIFT);
        end
        raw = int'(cfg_center) + step;
        if (raw > int'(cfg_center) + int'(cfg_span)) begin
            raw = int'(cfg_center) + int'(cfg_span);
        end
        if (raw < int'(cfg_center) - int'(cfg_span)) begin
            raw = int'(cfg_center) - int'(cfg_span);
        end
        return scpf_pkg::CH_W'(raw);
    endfunction

    function automatic scpf_pkg::t_q14 axis_value(input logic [scpf_pkg::AXIS_W-1:0] axis,
                                                  input scpf_pkg::t_q14 roll,
                                                  input scpf_pkg::t_q14 pitch,
                                                  input scpf_pkg::t_q14 yaw,
                                                  input scpf_pkg::t_q14 throttle);
        case (axis)
            scpf_pkg::AXIS_ROLL:     return roll;
            scpf_pkg::AXIS_PITCH:    return pitch;
            scpf_pkg::AXIS_YAW:      return yaw;
            scpf_pkg::AXIS_THROTTLE: return throttle;
            default:                 return '0;
        endcase
    endfunction

    // Build the 18-byte payload for one stick word and queue it
    function automatic void predict_payload(input scpf_pkg::t_q14 roll,
                                            input scpf_pkg::t_q14 pitch,
                                            input scpf_pkg::t_q14 yaw,
                                            input scpf_pkg::t_q14 throttle);
        logic [scpf_pkg::WORD_W-1:0] channels;
        logic [7:0]                  payload [scpf_pkg::FRAME_LEN];
        t_frame_byte                 fb;
        int                          i;
        channels = '0;
        channels[scpf_pkg::MARK_BIT] = 1'b1;
        for (i = 0; i < scpf_pkg::CHANNEL_COUNT; i++) begin
            channels |= scpf_pkg::WORD_W'(channel_code(axis_value(cfg_axis[i], roll, pitch,
                                                                  yaw, throttle)))
                        << scpf_pkg::CH_SHIFT[i];
        end
        payload[0] = 8'h01;
        payload[1] = 8'd13;
        for (i = 0; i < 8; i++) begin
            payload[2 + i] = channels[8 * i +: 8];
        end
        for (i = 0; i < 4; i++) begin
            payload[10 + i] = cfg_flags[8 * i +: 8];
        end
        payload[14] = 8'h06;
        payload[15] = 8'h55;
        payload[16] = 8'h01;
        payload[17] = 8'h04;
        for (i = 0; i < scpf_pkg::FRAME_LEN; i++) begin
            fb.data = payload[i];
            fb.last = (i == scpf_pkg::FRAME_LEN - 1);
            expected_bytes.insert(expected_bytes.size(), fb);
        end
    endfunction

    // Send one stick word, with an optional random gap ahead of it
    task automatic send_sticks(input int roll, input int pitch, input int yaw,
                               input int throttle);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_roll_value     <= scpf_pkg::t_q14'(roll);
        i_pitch_value    <= scpf_pkg::t_q14'(pitch);
        i_yaw_value      <= scpf_pkg::t_q14'(yaw);
        i_throttle_value <= scpf_pkg::t_q14'(throttle);
        do @(posedge i_clk); while (o_busy !== 1'b0);
        predict_payload(scpf_pkg::t_q14'(roll), scpf_pkg::t_q14'(pitch),
                        scpf_pkg::t_q14'(yaw), scpf_pkg::t_q14'(throttle));
    endtask

    // Hold off new words until every queued payload byte has come out
    task automatic settle();
        i_start <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [scpf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [scpf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            scpf_pkg::REG_CENTER: cfg_center  = data[scpf_pkg::CH_W-1:0];
            scpf_pkg::REG_SPAN:   cfg_span    = data[scpf_pkg::SPAN_W-1:0];
            scpf_pkg::REG_FLAGS:  cfg_flags   = data[scpf_pkg::FLAGS_W-1:0];
            scpf_pkg::REG_SLOT0:  cfg_axis[0] = data[scpf_pkg::AXIS_W-1:0];
            scpf_pkg::REG_SLOT1:  cfg_axis[1] = data[scpf_pkg::AXIS_W-1:0];
            scpf_pkg::REG_SLOT2:  cfg_axis[2] = data[scpf_pkg::AXIS_W-1:0];
            scpf_pkg::REG_SLOT3:  cfg_axis[3] = data[scpf_pkg::AXIS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_axes(input logic [scpf_pkg::AXIS_W-1:0] a0,
                              input logic [scpf_pkg::AXIS_W-1:0] a1,
                              input logic [scpf_pkg::AXIS_W-1:0] a2,
                              input logic [scpf_pkg::AXIS_W-1:0] a3);
        write_reg(scpf_pkg::REG_SLOT0, scpf_pkg::CFG_DATA_W'(a0));
        write_reg(scpf_pkg::REG_SLOT1, scpf_pkg::CFG_DATA_W'(a1));
        write_reg(scpf_pkg::REG_SLOT2, scpf_pkg::CFG_DATA_W'(a2));
        write_reg(scpf_pkg::REG_SLOT3, scpf_pkg::CFG_DATA_W'(a3));
    endtask

    // Mix of full-range, boundary, near-zero and in-range stick values
    function automatic int random_stick();
        case ($urandom_range(0, 5))
            0: return int'(scpf_pkg::t_q14'($urandom));
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16384;
                    1: return -16384;
                    2: return 32767;
                    default: return -32768;
                endcase
            end
            2: return int'($urandom_range(0, 600)) - 300;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    // Reset configuration straight out of reset
    task automatic test_reset_defaults();
        send_sticks(0, 0, 0, 0);
        send_sticks(16384, -16384, 32767, -32768);
        send_sticks(8192, -8192, 1, -1);
    endtask

    // Exact half steps round away from zero; just under half rounds toward it
    task automatic test_rounding();
        settle();
        write_reg(scpf_pkg::REG_SPAN, 32'd1);
        send_sticks(8192, -8192, 8191, -8191);
        send_sticks(24576, -24576, 16384, -16384);
        settle();
        write_reg(scpf_pkg::REG_SPAN, 32'd2);
        send_sticks(4096, -4096, 4095, -4097);
    endtask

    // Axis routing, zero and undefined codes, masked write data, unused index
    task automatic test_axis_select();
        settle();
        write_reg(scpf_pkg::REG_CENTER, 32'd1024);
        write_reg(scpf_pkg::REG_SPAN, 32'd1023);
        write_axes(scpf_pkg::AXIS_THROTTLE, scpf_pkg::AXIS_YAW, scpf_pkg::AXIS_PITCH,
                   scpf_pkg::AXIS_ROLL);
        send_sticks(1000, -2000, 3000, -4000);
        settle();
        write_axes(scpf_pkg::AXIS_ZERO, AXIS_RSVD5, AXIS_RSVD6, AXIS_RSVD7);
        send_sticks(16384, 16384, 16384, 16384);
        settle();
        write_reg(scpf_pkg::REG_SLOT0, 32'hFFFF_FFF8 | scpf_pkg::CFG_DATA_W'(scpf_pkg::AXIS_ROLL));
        write_reg(scpf_pkg::REG_SLOT1, 32'hFFFF_FFF8 | scpf_pkg::CFG_DATA_W'(scpf_pkg::AXIS_ROLL));
        write_reg(scpf_pkg::REG_SLOT2, 32'hFFFF_FFF8 | scpf_pkg::CFG_DATA_W'(scpf_pkg::AXIS_ROLL));
        write_reg(scpf_pkg::REG_SLOT3, 32'hFFFF_FFF8 | scpf_pkg::CFG_DATA_W'(scpf_pkg::AXIS_ROLL));
        send_sticks(-5000, 1, 2, 3);
        settle();
        write_reg(REG_NONE, 32'hFFFF_FFFF);
        send_sticks(7, 7, 7, 7);
    endtask

    // Clamp beyond full stick, negative and overflowing wrap, zero span, flags
    task automatic test_clamp_and_wrap();
        settle();
        write_axes(scpf_pkg::AXIS_ROLL, scpf_pkg::AXIS_PITCH, scpf_pkg::AXIS_YAW,
                   scpf_pkg::AXIS_THROTTLE);
        write_reg(scpf_pkg::REG_CENTER, 32'd0);
        write_reg(scpf_pkg::REG_SPAN, 32'hFFFF_FFFF);
        send_sticks(-16384, 16384, -32768, 32767);
        settle();
        write_reg(scpf_pkg::REG_CENTER, 32'hFFFF_FFFF);
        send_sticks(16384, -16384, 32767, -32768);
        settle();
        write_reg(scpf_pkg::REG_SPAN, 32'd0);
        write_reg(scpf_pkg::REG_FLAGS, 32'hFFFF_FFFF);
        send_sticks(32767, -32768, 100, -100);
        settle();
        write_reg(scpf_pkg::REG_CENTER, 32'd1024);
        write_reg(scpf_pkg::REG_SPAN, 32'd660);
        write_reg(scpf_pkg::REG_FLAGS, 32'hA5C3_0F81);
        send_sticks(32767, -32768, 0, -1);
        send_sticks(-1, 0, 16383, -16383);
    endtask

    // Fresh random configuration once the framer has drained
    task automatic random_config(input int phase);
        logic [scpf_pkg::CFG_DATA_W-1:0] center;
        logic [scpf_pkg::CFG_DATA_W-1:0] span;
        int                              i;
        settle();
        case (phase)
            0: begin center = 0;    span = 1023; end
            1: begin center = 2047; span = 1023; end
            2: begin center = 1024; span = 0;    end
            default: begin
                center = $urandom_range(0, 2047);
                span   = $urandom_range(0, 1023);
            end
        endcase
        write_reg(scpf_pkg::REG_CENTER, ($urandom << scpf_pkg::CH_W) | center);
        write_reg(scpf_pkg::REG_SPAN, ($urandom << scpf_pkg::SPAN_W) | span);
        write_reg(scpf_pkg::REG_FLAGS, $urandom);
        for (i = 0; i < scpf_pkg::CHANNEL_COUNT; i++) begin
            write_reg(scpf_pkg::CFG_IDX_W'(scpf_pkg::REG_SLOT0 + i),
                      ($urandom << scpf_pkg::AXIS_W) | (($urandom_range(0, 3) == 0) ?
                                              $urandom_range(4, 7) : $urandom_range(0, 3)));
        end
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_NONE, $urandom);
        end
    endtask

    // Phases of random sticks; gaps vary per phase and stop near the end
    task automatic test_random_traffic();
        int phase;
        int n;
        int per_phase;
        per_phase = RANDOM_ITEMS / PHASE_COUNT;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            random_config(phase);
            if (phase >= PHASE_COUNT - 2) begin
                gap_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 10;
                    default: gap_pct = 40;
                endcase
            end
            for (n = 0; n < per_phase; n++) begin
                // hold the sender once until the pipeline is empty
                if (phase == 3 && n == per_phase / 2) begin
                    settle();
                end
                send_sticks(random_stick(), random_stick(), random_stick(), random_stick());
            end
        end
        gap_pct = 0;
    endtask

    // Compare each payload byte with the oldest expectation
    always @(posedge i_clk) begin
        t_frame_byte exp_b;
        if (i_rst_n === 1'b1 && o_frame_valid === 1'b1) begin
            if (expected_bytes.size() == 0) begin
                error_count++;
                $display("%0t: unexpected payload byte: expected none, actual %02h last %b",
                         $time, o_frame_byte, o_frame_last);
            end else begin
                exp_b = expected_bytes.pop_front();
                if (o_frame_byte !== exp_b.data) begin
                    error_count++;
                    $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                             $time, exp_b.data, o_frame_byte);
                end
                if (o_frame_last !== exp_b.last) begin
                    error_count++;
                    $display("%0t: frame_last mismatch: expected %b, actual %b",
                             $time, exp_b.last, o_frame_last);
                end
            end
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_start === 1'b1 && o_busy === 1'b0) || o_frame_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_start          <= 1'b0;
        i_roll_value     <= '0;
        i_pitch_value    <= '0;
        i_yaw_value      <= '0;
        i_throttle_value <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= '0;
        i_cfg_wdata      <= '0;
        cfg_center  = 11'd1024;
        cfg_span    = 10'd660;
        cfg_flags   = '0;
        cfg_axis[0] = scpf_pkg::AXIS_ROLL;
        cfg_axis[1] = scpf_pkg::AXIS_PITCH;
        cfg_axis[2] = scpf_pkg::AXIS_YAW;
        cfg_axis[3] = scpf_pkg::AXIS_THROTTLE;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_rounding();
        test_axis_select();
        test_clamp_and_wrap();
        test_random_traffic();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
